[src/prang_pkg.sv]
// prang_pkg: shared types, constants and the arctangent table for the pixel ray angle unit
// no dependencies
package prang_pkg;

  localparam int unsigned PixelBits = 12;
  localparam int unsigned AngleIterations = 16;
  localparam int unsigned RegBits = 16;
  localparam int unsigned AngleBits = 17;
  localparam int unsigned PreShift = 10;
  localparam int unsigned NumIter = (AngleIterations > 32) ? 32 : AngleIterations;
  // cordic datapath: |offset| < 2^(PixelBits+4)+2^16, shifted by PreShift, grows ~1.65x
  localparam int unsigned OffBits = ((PixelBits + 4 > RegBits) ? PixelBits + 4 : RegBits) + 1;
  localparam int unsigned XyBits = OffBits + PreShift + 3;
  localparam int unsigned ZBits = 34;
  localparam int unsigned RegIdxBits = 2;
  localparam logic [AngleBits-1:0] HalfPiQ16 = AngleBits'(102944);

  typedef enum logic [RegIdxBits-1:0] {
    REG_FOCAL_X  = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_FOCAL_Y  = 2'd2,
    REG_CENTER_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PixelBits-1:0] pixel_col;
    logic [PixelBits-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [AngleBits-1:0] angle_about_x;
    logic [AngleBits-1:0] angle_about_y;
  } out_word_t;

  // one axis as it travels through the cordic stages
  typedef struct packed {
    logic              zero_off;
    logic              zero_focal;
    logic signed [XyBits-1:0] x;
    logic signed [XyBits-1:0] y;
    logic signed [ZBits-1:0]  z;
  } axis_t;

  function automatic logic [ZBits-1:0] atan_q30(input logic [4:0] i);
    logic [ZBits-1:0] r;
    case (i)
      5'd0: r = ZBits'(843314857);
      5'd1: r = ZBits'(497837829);
      5'd2: r = ZBits'(263043837);
      5'd3: r = ZBits'(133525159);
      5'd4: r = ZBits'(67021687);
      5'd5: r = ZBits'(33543516);
      5'd6: r = ZBits'(16775851);
      5'd7: r = ZBits'(8388437);
      5'd8: r = ZBits'(4194283);
      5'd9: r = ZBits'(2097149);
      5'd31: r = '0;
      default: r = ZBits'(64'd1) << (5'd30 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [XyBits-1:0] shr_tz(input logic signed [XyBits-1:0] v,
                                                     input logic [4:0] s);
    logic [XyBits-1:0] m;
    m = v[XyBits-1] ? XyBits'(-v) : XyBits'(v);
    m = m >> s;
    return v[XyBits-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[src/pixel_ray_axis_angles_unit.sv]
// pixel_ray_axis_angles_unit: top level, camera registers, prep stage, cordic pipe, output stage
// depends on prang_pkg, prang_prep, prang_cordic_step, prang_finish
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | pixel_col, pixel_row
// out     | output    | out_valid/out_ready| angle_about_x, angle_about_y
// cfg     | input     | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// one word per cycle while the output register is empty or being taken; AngleIterations is capped at 32
// one register stage per cordic iteration, plus input and output stages
// the whole pipe advances when the output register is empty or being taken
// reset loads the default camera registers and empties the pipe
module pixel_ray_axis_angles_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  prang_pkg::in_word_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output prang_pkg::out_word_t                 out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [prang_pkg::RegIdxBits-1:0]     cfg_idx_i,
  input  logic [prang_pkg::RegBits-1:0]        cfg_data_i
);
  localparam int unsigned N = prang_pkg::NumIter;

  logic [prang_pkg::RegBits-1:0] focal_x_q, center_x_q, focal_y_q, center_y_q;
  logic en;
  logic in_valid_q;
  prang_pkg::axis_t px, py, in_ax_q, in_ay_q;
  logic             v [N+1];
  prang_pkg::axis_t ax [N+1];
  prang_pkg::axis_t ay [N+1];
  logic [prang_pkg::AngleBits-1:0] ang_x, ang_y;
  logic out_valid_q;
  prang_pkg::out_word_t out_q;

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= prang_pkg::RegBits'(5247);
      center_x_q <= prang_pkg::RegBits'(4719);
      focal_y_q  <= prang_pkg::RegBits'(5256);
      center_y_q <= prang_pkg::RegBits'(4916);
    end else if (cfg_we_i) begin
      case (prang_pkg::reg_idx_e'(cfg_idx_i))
        prang_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        prang_pkg::REG_CENTER_X: center_x_q <= cfg_data_i;
        prang_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        prang_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  prang_prep u_prep_x (.pixel_i(in_data_i.pixel_col), .center_i(center_x_q),
                       .focal_i(focal_x_q), .axis_o(px));
  prang_prep u_prep_y (.pixel_i(in_data_i.pixel_row), .center_i(center_y_q),
                       .focal_i(focal_y_q), .axis_o(py));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_ax_q <= px;
      in_ay_q <= py;
    end
  end

  assign v[0]  = in_valid_q;
  assign ax[0] = in_ax_q;
  assign ay[0] = in_ay_q;

  for (genvar g = 0; g < N; g++) begin : g_iter
    prang_cordic_step u_step (
      .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .iter_i(5'(g)),
      .valid_i(v[g]), .ax_i(ax[g]), .ay_i(ay[g]),
      .valid_o(v[g+1]), .ax_o(ax[g+1]), .ay_o(ay[g+1])
    );
  end

  prang_finish u_fin_x (.axis_i(ax[N]), .angle_o(ang_x));
  prang_finish u_fin_y (.axis_i(ay[N]), .angle_o(ang_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.angle_about_x <= ang_x;
      out_q.angle_about_y <= ang_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

[src/prang_prep.sv]
// prang_prep: forms offset magnitude and scaled focal length for one axis
// depends on prang_pkg
module prang_prep (
  input  logic [prang_pkg::PixelBits-1:0] pixel_i,
  input  logic [prang_pkg::RegBits-1:0]   center_i,
  input  logic [prang_pkg::RegBits-1:0]   focal_i,
  output prang_pkg::axis_t                axis_o
);
  logic signed [prang_pkg::OffBits-1:0] off;
  logic [prang_pkg::OffBits-1:0] mag;

  always_comb begin
    off = $signed(prang_pkg::OffBits'({pixel_i, 4'b0000}))
        - $signed(prang_pkg::OffBits'(center_i));
    mag = off[prang_pkg::OffBits-1] ? prang_pkg::OffBits'(-off) : prang_pkg::OffBits'(off);
    axis_o.zero_off   = (mag == '0);
    axis_o.zero_focal = (focal_i == '0);
    axis_o.x = $signed(prang_pkg::XyBits'(focal_i) << prang_pkg::PreShift);
    axis_o.y = $signed(prang_pkg::XyBits'(mag) << prang_pkg::PreShift);
    axis_o.z = '0;
  end
endmodule

[src/prang_cordic_step.sv]
// prang_cordic_step: one registered vectoring cordic rotation for both axes
// depends on prang_pkg
module prang_cordic_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [4:0]       iter_i,
  input  logic             valid_i,
  input  prang_pkg::axis_t ax_i,
  input  prang_pkg::axis_t ay_i,
  output logic             valid_o,
  output prang_pkg::axis_t ax_o,
  output prang_pkg::axis_t ay_o
);
  logic valid_q;
  prang_pkg::axis_t ax_q, ax_d, ay_q, ay_d;

  function automatic prang_pkg::axis_t rot(input prang_pkg::axis_t a, input logic [4:0] i);
    prang_pkg::axis_t r;
    logic signed [prang_pkg::XyBits-1:0] xs, ys;
    r = a;
    xs = prang_pkg::shr_tz(a.x, i);
    ys = prang_pkg::shr_tz(a.y, i);
    if (a.y > 0) begin
      r.x = a.x + ys;
      r.y = a.y - xs;
      r.z = a.z + $signed(prang_pkg::atan_q30(i));
    end else begin
      r.x = a.x - ys;
      r.y = a.y + xs;
      r.z = a.z - $signed(prang_pkg::atan_q30(i));
    end
    return r;
  endfunction

  assign ax_d = rot(ax_i, iter_i);
  assign ay_d = rot(ay_i, iter_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  assign valid_o = valid_q;
  assign ax_o = ax_q;
  assign ay_o = ay_q;
endmodule

[src/prang_finish.sv]
// prang_finish: rounds the accumulated angle to 16 fractional bits and clamps it to 0..pi/2;
// zero offset gives 0, zero focal gives pi/2; depends on prang_pkg
module prang_finish (
  input  prang_pkg::axis_t                axis_i,
  output logic [prang_pkg::AngleBits-1:0] angle_o
);
  logic signed [prang_pkg::ZBits-1:0] zr;

  always_comb begin
    zr = (axis_i.z + $signed(prang_pkg::ZBits'(1 << 13))) >>> 14;
    if (axis_i.zero_off) begin
      angle_o = '0;
    end else if (axis_i.zero_focal) begin
      angle_o = prang_pkg::HalfPiQ16;
    end else if (axis_i.z <= 0) begin
      angle_o = '0;
    end else if (zr > $signed(prang_pkg::ZBits'(prang_pkg::HalfPiQ16))) begin
      angle_o = prang_pkg::HalfPiQ16;
    end else begin
      angle_o = prang_pkg::AngleBits'(zr);
    end
  end
endmodule

[tb/sv/pixel_ray_axis_angles_unit_tb.sv]
// pixel_ray_axis_angles_unit_tb: self-checking testbench for the pixel ray angle unit
// predicts both axis angles with its own integer cordic and checks every output word
// depends on prang_pkg and pixel_ray_axis_angles_unit
`timescale 1ns / 100ps

module pixel_ray_axis_angles_unit_tb;
  import prang_pkg::*;

  localparam int unsigned PipeDepth = NumIter + 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [RegIdxBits-1:0] cfg_idx_i = '0;
  logic [RegBits-1:0] cfg_data_i = '0;

  logic [RegBits-1:0] cam_regs [4];
  out_word_t angle_queue [$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned cfg_writes = 0;
  bit sink_hold = 1'b0;
  int unsigned sink_wait = 0;

  always #5 clk_i = ~clk_i;

  pixel_ray_axis_angles_unit uut (.*);

  function automatic longint tz_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic logic [AngleBits-1:0] ray_angle(logic [PixelBits-1:0] pix,
                                                     logic [RegBits-1:0] ctr,
                                                     logic [RegBits-1:0] foc);
    longint off, x, y, z, xs, ys;
    longint atab [32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    off = longint'(pix) * 16 - longint'(ctr);
    if (off < 0) off = -off;
    if (off == 0) return '0;
    if (foc == 0) return HalfPiQ16;
    x = longint'(foc) << PreShift;
    y = off << PreShift;
    z = 0;
    for (int i = 0; i < NumIter; i++) begin
      xs = tz_shift(x, i);
      ys = tz_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atab[i];
      end else begin
        x -= ys; y += xs; z -= atab[i];
      end
    end
    if (z <= 0) return '0;
    z = (z + (64'sd1 <<< 13)) / (64'sd1 <<< 14);
    if (z > 102944) z = 102944;
    return AngleBits'(z);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // leaves valid high on return; the next call or drain decides what follows
  task automatic send_pixel(logic [PixelBits-1:0] col, logic [PixelBits-1:0] row,
                            bit with_gaps);
    out_word_t w;
    int unsigned gap;
    gap = with_gaps ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    w.angle_about_x = ray_angle(col, cam_regs[REG_CENTER_X], cam_regs[REG_FOCAL_X]);
    w.angle_about_y = ray_angle(row, cam_regs[REG_CENTER_Y], cam_regs[REG_FOCAL_Y]);
    in_valid_i <= 1'b1;
    in_data_i <= '{pixel_col: col, pixel_row: row};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    angle_queue.push_back(w);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (angle_queue.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (PipeDepth + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [RegBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cam_regs[idx] = val;
    cfg_writes++;
  endtask

  task automatic set_camera(logic [RegBits-1:0] fx, logic [RegBits-1:0] cx,
                            logic [RegBits-1:0] fy, logic [RegBits-1:0] cy);
    drain();
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_Y, cy);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_defaults();
    logic [PixelBits-1:0] edges [6] = '{12'd0, 12'd4095, 12'd294, 12'd307, 12'd1, 12'd2048};
    foreach (edges[i]) send_pixel(edges[i], edges[5 - i], 1'b0);
    send_pixel(12'd294, 12'd307, 1'b0);
  endtask

  task automatic test_special_cases();
    set_camera(16'd0, 16'd1600, 16'd0, 16'd0);
    send_pixel(12'd100, 12'd0, 1'b0);
    send_pixel(12'd101, 12'd4095, 1'b0);
    set_camera(16'd16, 16'd65535, 16'd65535, 16'd0);
    send_pixel(12'd0, 12'd4095, 1'b0);
    send_pixel(12'd4095, 12'd1, 1'b0);
    set_camera(16'd65535, 16'd0, 16'd16, 16'd65535);
    send_pixel(12'd4095, 12'd0, 1'b0);
    send_pixel(12'd0, 12'd4095, 1'b0);
    send_pixel(12'd1, 12'd2048, 1'b0);
  endtask

  task automatic test_random(int unsigned n);
    for (int p = 0; p < 4; p++) begin
      set_camera(16'($urandom_range(16, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(16, 65535)), 16'($urandom_range(0, 65535)));
      if (p == 2) set_camera(16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)));
      for (int k = 0; k < n / 4; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel(12'(cam_regs[REG_CENTER_X] >> 4), 12'(cam_regs[REG_CENTER_Y] >> 4), 1'b1);
        else
          send_pixel(12'($urandom()), 12'($urandom()), (k % 200) > 50);
      end
    end
  endtask

  task automatic test_backpressure();
    set_camera(16'd5247, 16'd4719, 16'd5256, 16'd4916);
    sink_hold = 1'b1;
    fork
      begin
        repeat (3 * PipeDepth) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      for (int k = 0; k < 3 * PipeDepth; k++) send_pixel(12'($urandom()), 12'($urandom()), 1'b0);
    join
    drain();
    for (int k = 0; k < 40; k++) send_pixel(12'($urandom()), 12'($urandom()), 1'b0);
  endtask

  always @(negedge clk_i) begin
    if (sink_hold) begin
      out_ready_i <= 1'b0;
    end else if (sink_wait != 0) begin
      out_ready_i <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else if ($urandom_range(0, 99) < 10) begin
      out_ready_i <= 1'b0;
      sink_wait <= gap_len();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angle_queue.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, out_data_o);
        n_errors++;
      end else begin
        exp_w = angle_queue.pop_front();
        n_checked++;
        if (exp_w.angle_about_x !== out_data_o.angle_about_x) begin
          $display("%0t angle_about_x mismatch: expected %0d actual %0d", $time,
                   exp_w.angle_about_x, out_data_o.angle_about_x);
          n_errors++;
        end
        if (exp_w.angle_about_y !== out_data_o.angle_about_y) begin
          $display("%0t angle_about_y mismatch: expected %0d actual %0d", $time,
                   exp_w.angle_about_y, out_data_o.angle_about_y);
          n_errors++;
        end
      end
    end
  end

  initial begin
    cam_regs[REG_FOCAL_X] = 16'd5247;
    cam_regs[REG_CENTER_X] = 16'd4719;
    cam_regs[REG_FOCAL_Y] = 16'd5256;
    cam_regs[REG_CENTER_Y] = 16'd4916;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_special_cases();
    test_backpressure();
    test_random(1600);
    drain();
    if (angle_queue.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, angle_queue.size());
      n_errors++;
    end
    $display("sent %0d pixels, checked %0d angle words, %0d camera register writes",
             n_sent, n_checked, cfg_writes);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/prang_pkg.sv
src/prang_prep.sv
src/prang_cordic_step.sv
src/prang_finish.sv
src/pixel_ray_axis_angles_unit.sv
tb/sv/pixel_ray_axis_angles_unit_tb.sv
